// ===== sv/pqsr_pkg.sv =====
package pqsr_pkg;

	// Queue geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PRIO_WIDTH = 8;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int WORD_W     = DATA_WIDTH + PRIO_WIDTH;

	// Action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                  action;
		logic [DATA_WIDTH-1:0] data_in;
		logic [PRIO_WIDTH-1:0] prio_in;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [DATA_WIDTH-1:0] data_out;
		logic [PRIO_WIDTH-1:0] prio_out;
		logic [CNT_W-1:0]      fill_level;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic push;
		logic rej_full;
		logic rej_empty;
		logic scan_init;
		logic rd_issue;
		logic shift;
		logic shift_init;
		logic take_head;
		logic finish_shift;
		logic resp_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic rem_zero;
		logic rd_busy;
		logic best_at_head;
		logic ptr_at_tail;
		logic out_free;
	} ctl_sts_t;

	// Ring index stepping, valid for any depth
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

// ===== sv/priority_queue_scan_remove.sv =====
// Channel  Direction  Payload             Handshake
// req      into       pqsr_pkg::req_t     req_valid / req_stall
// rsp      out of     pqsr_pkg::rsp_t     rsp_valid / rsp_stall
//
// A push or a rejected item is accepted, then its result is loaded.
// A pop over n held entries is accepted, scanned through the single read port of the entry
// store, picked, has its gap closed when the pick is not the head, then loaded.
// One item is worked at a time; req_stall is high from acceptance until its result is loaded.
// A waiting result does not hold up the next item, only the next result load.
// arst_n clears pointers, fill count and handshake state; the entry store is not cleared.
module priority_queue_scan_remove (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pqsr_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pqsr_pkg::rsp_t   rsp
);

	import pqsr_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	pqsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action   (req.action),
		.sts      (sts),
		.cmd      (cmd)
	);

	pqsr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== sv/pqsr_ram.sv =====
module pqsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/pqsr_ctrl.sv =====
module pqsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              action,
	input  pqsr_pkg::ctl_sts_t sts,
	output pqsr_pkg::ctl_cmd_t cmd
);

	import pqsr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_PICK  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	// Sequence one item at a time
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_PUSH) begin
						cmd.push     = !sts.full;
						cmd.rej_full = sts.full;
						state_d      = S_RESP;
					end else if (sts.empty) begin
						cmd.rej_empty = 1'b1;
						state_d       = S_RESP;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (!sts.rem_zero) begin
					cmd.rd_issue = 1'b1;
				end else if (!sts.rd_busy) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (sts.best_at_head) begin
					cmd.take_head = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (!sts.ptr_at_tail) begin
					cmd.rd_issue = 1'b1;
				end else if (!sts.rd_busy) begin
					cmd.finish_shift = 1'b1;
					state_d          = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A gap is closed only after a pick away from the head
	a_shift_after_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SHIFT) |-> $past(state_q == S_PICK) && $past(!sts.best_at_head))
		else $error("shift entered without a pick behind the head");

	// Pick follows a finished scan
	a_pick_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> $past(state_q == S_SCAN) && $past(sts.rem_zero))
		else $error("pick reached before the scan ended");

	// Stall drops only on leaving the response state
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_stall) |-> $past(cmd.resp_load))
		else $error("stall released without loading a response");

endmodule

// ===== sv/pqsr_dp.sv =====
module pqsr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pqsr_pkg::req_t     req,
	input  pqsr_pkg::ctl_cmd_t cmd,
	output pqsr_pkg::ctl_sts_t sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pqsr_pkg::rsp_t     rsp
);

	import pqsr_pkg::*;

	logic [IDX_W-1:0]      head_q, tail_q, ptr_q, best_idx_q, rd_idx_s1;
	logic [CNT_W-1:0]      count_q, rem_q;
	logic                  rd_vld_s1, best_vld_q, out_valid_q;
	logic [PRIO_WIDTH-1:0] best_prio_q;
	logic [DATA_WIDTH-1:0] best_data_q;
	rsp_t                  res_q, out_q;

	logic                  wr_en, wr_shift, take_new;
	logic [IDX_W-1:0]      wr_addr;
	logic [WORD_W-1:0]     wr_data, rd_data;
	logic [DATA_WIDTH-1:0] rd_dat;
	logic [PRIO_WIDTH-1:0] rd_prio;

	assign rd_dat  = rd_data[WORD_W-1:PRIO_WIDTH];
	assign rd_prio = rd_data[PRIO_WIDTH-1:0];

	// Write at the tail on push, one slot back from the read during a shift
	assign wr_shift = rd_vld_s1 && cmd.shift;
	assign wr_en    = cmd.push || wr_shift;
	assign wr_addr  = cmd.push ? tail_q : prev_idx(rd_idx_s1);
	assign wr_data  = cmd.push ? {req.data_in, req.prio_in} : rd_data;

	pqsr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_issue),
		.rd_addr(ptr_q),
		.rd_data(rd_data)
	);

	// Strict compare keeps the earliest entry on a tie
	assign take_new = rd_vld_s1 && !cmd.shift && (!best_vld_q || (rd_prio > best_prio_q));

	assign sts.full         = (count_q == CNT_W'(DEPTH));
	assign sts.empty        = (count_q == '0);
	assign sts.rem_zero     = (rem_q == '0);
	assign sts.rd_busy      = rd_vld_s1;
	assign sts.best_at_head = (best_idx_q == head_q);
	assign sts.ptr_at_tail  = (ptr_q == tail_q);
	assign sts.out_free     = !out_valid_q || !rsp_stall;

	// Ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.push) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.take_head) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.finish_shift) begin
				tail_q  <= prev_idx(tail_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Walk pointer, remaining count and best candidate
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if (cmd.scan_init) begin
			ptr_q      <= head_q;
			rem_q      <= count_q;
			best_vld_q <= 1'b0;
		end else if (cmd.shift_init) begin
			ptr_q <= next_idx(best_idx_q);
		end else if (cmd.rd_issue) begin
			ptr_q <= next_idx(ptr_q);
			if (!cmd.shift) begin
				rem_q <= rem_q - 1'b1;
			end
		end
		if (take_new) begin
			best_vld_q  <= 1'b1;
			best_idx_q  <= rd_idx_s1;
			best_prio_q <= rd_prio;
			best_data_q <= rd_dat;
		end
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_q <= '{status: ST_DONE, data_out: '0, prio_out: '0,
				fill_level: count_q + 1'b1};
		end else if (cmd.rej_full) begin
			res_q <= '{status: ST_FULL, data_out: '0, prio_out: '0, fill_level: count_q};
		end else if (cmd.rej_empty) begin
			res_q <= '{status: ST_EMPTY, data_out: '0, prio_out: '0, fill_level: count_q};
		end else if (cmd.take_head || cmd.finish_shift) begin
			res_q <= '{status: ST_DONE, data_out: best_data_q, prio_out: best_prio_q,
				fill_level: count_q - 1'b1};
		end
	end

	// Output register: hold the beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_ring_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (count_q == '0 || count_q == CNT_W'(DEPTH)))
		else $error("head, tail and count disagree");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status != ST_DONE) |-> (out_q.data_out == '0)
			&& (out_q.prio_out == '0))
		else $error("rejected beat carries a payload");

	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && wr_shift))
		else $error("push and shift write collide");

endmodule

// ===== dv/pqsr_checker.sv =====
module pqsr_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  pqsr_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  pqsr_pkg::rsp_t rsp,
	input  logic           end_check,
	output int             fail_count,
	output int             results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import pqsr_pkg::*;

	// Shadow copy of the queue contents
	logic [DATA_WIDTH-1:0] slot_data [DEPTH];
	logic [PRIO_WIDTH-1:0] slot_prio [DEPTH];
	int head_idx;
	int tail_idx;
	int held;

	rsp_t awaited_results [$];
	rsp_t want;

	initial begin
		fail_count   = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < 60) begin
			$display("[%0t] MISMATCH %s", $realtime, msg);
		end
		fail_count++;
	endtask

	// Apply one request to the shadow queue and return the result it should give
	function automatic rsp_t serve_request(input req_t r);
		rsp_t res;
		int best;
		int pos;
		int dst;
		int src;
		res = '0;
		res.status = ST_DONE;
		if (r.action == ACT_PUSH) begin
			if (held == DEPTH) begin
				res.status = ST_FULL;
			end else begin
				slot_data[tail_idx] = r.data_in;
				slot_prio[tail_idx] = r.prio_in;
				tail_idx = (tail_idx + 1) % DEPTH;
				held++;
			end
		end else if (held == 0) begin
			res.status = ST_EMPTY;
		end else begin
			// strict compare keeps the earliest arrival on a tie
			best = head_idx;
			pos  = head_idx;
			for (int k = 0; k < held; k++) begin
				if (slot_prio[pos] > slot_prio[best])
					best = pos;
				pos = (pos + 1) % DEPTH;
			end
			res.data_out = slot_data[best];
			res.prio_out = slot_prio[best];
			if (best == head_idx) begin
				head_idx = (head_idx + 1) % DEPTH;
			end else begin
				// close the gap: later entries move one slot toward the head
				dst = best;
				src = (best + 1) % DEPTH;
				while (src != tail_idx) begin
					slot_data[dst] = slot_data[src];
					slot_prio[dst] = slot_prio[src];
					dst = src;
					src = (src + 1) % DEPTH;
				end
				tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
			end
			held--;
		end
		res.fill_level = CNT_W'(held);
		return res;
	endfunction

	// Watch both channels; compare results first, then predict the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			held     = 0;
			awaited_results.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing awaited: %h", rsp));
				end else begin
					want = awaited_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							rsp.status, want.status));
					if (rsp.data_out !== want.data_out)
						report_mismatch($sformatf("data_out got %h expected %h",
							rsp.data_out, want.data_out));
					if (rsp.prio_out !== want.prio_out)
						report_mismatch($sformatf("prio_out got %h expected %h",
							rsp.prio_out, want.prio_out));
					if (rsp.fill_level !== want.fill_level)
						report_mismatch($sformatf("fill_level got %0d expected %0d",
							rsp.fill_level, want.fill_level));
				end
			end
			if (req_valid && !req_stall)
				awaited_results.push_back(serve_request(req));
			// flag anything still awaited once the run has drained
			if (end_check) begin
				while (awaited_results.size() != 0) begin
					want = awaited_results.pop_front();
					report_mismatch($sformatf("result never arrived: %h", want));
				end
			end
		end
	end

endmodule

// ===== dv/tb_priority_queue_scan_remove.sv =====
module tb_priority_queue_scan_remove;
	timeunit 1ns;
	timeprecision 1ps;

	import pqsr_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 12;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_LONG} stall_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic end_check = 1'b0;

	int fail_count;
	int results_seen;
	int items_sent = 0;
	int cycles     = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int  mode_left = 0;
	int  run_left  = 0;
	logic run_stall = 1'b0;

	priority_queue_scan_remove dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pqsr_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.end_check    (end_check),
		.fail_count   (fail_count),
		.results_seen (results_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result-side back-pressure: switch between no stall, sparse stalls and long stalls
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			mode_left  = $urandom_range(20, 200);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_SPARSE: begin
				rsp_stall <= ($urandom_range(0, 9) < 3);
			end
			default: begin
				if (run_left == 0) begin
					run_stall = !run_stall;
					run_left  = run_stall ? $urandom_range(1, 30) : $urandom_range(1, 10);
				end
				run_left--;
				rsp_stall <= run_stall;
			end
		endcase
	end

	// Present one request beat and hold it until accepted
	task automatic send_beat(input logic act, input logic [DATA_WIDTH-1:0] data,
			input logic [PRIO_WIDTH-1:0] prio);
		req_valid      <= 1'b1;
		req            <= '{action: act, data_in: data, prio_in: prio};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
	endtask

	initial begin
		int burst_len;
		int gap;
		int push_pct;
		int mode_items;
		int pick;
		int random_sent;
		logic [PRIO_WIDTH-1:0] prio;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pop on empty, fill to full with ties and extremes, push on full,
		// then seven pops through the middle of a full ring, the head and the next best
		send_beat(ACT_POP, '1, '1);
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0:       prio = 8'd200;
				3, 9:    prio = 8'hFF;
				5:       prio = 8'h00;
				default: prio = PRIO_WIDTH'((i * 11) & 8'h7F);
			endcase
			if (i == 3)
				send_beat(ACT_PUSH, '1, prio);
			else if (i == 5)
				send_beat(ACT_PUSH, '0, prio);
			else
				send_beat(ACT_PUSH, DATA_WIDTH'($urandom), prio);
		end
		send_beat(ACT_PUSH, '1, '1);
		repeat (7) send_beat(ACT_POP, DATA_WIDTH'($urandom), PRIO_WIDTH'($urandom));

		// Random: bursts with gaps, push bias drifting so the fill swings full and empty
		random_sent = 0;
		mode_items  = 0;
		push_pct    = 50;
		while (random_sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 24);
			for (int b = 0; b < burst_len; b++) begin
				if (mode_items == 0) begin
					case ($urandom_range(0, 2))
						0:       push_pct = 15;
						1:       push_pct = 50;
						default: push_pct = 85;
					endcase
					mode_items = $urandom_range(16, 64);
				end
				mode_items--;
				pick = $urandom_range(0, 9);
				if (pick <= 5)
					prio = PRIO_WIDTH'($urandom_range(0, 3));
				else if (pick <= 7)
					prio = PRIO_WIDTH'($urandom);
				else if (pick == 8)
					prio = '0;
				else
					prio = '1;
				send_beat(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP,
					DATA_WIDTH'($urandom), prio);
				random_sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		// Drain: every result back, then let the block settle
		wait (results_seen >= items_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pqsr_pkg.sv
sv/pqsr_ram.sv
sv/pqsr_ctrl.sv
sv/pqsr_dp.sv
sv/priority_queue_scan_remove.sv
dv/pqsr_checker.sv
dv/tb_priority_queue_scan_remove.sv
